FILE: sv/ocs_pkg.sv
// ----------------------------------------------------------------------------
// ocs_pkg
// Shared types and constants of the OFDM timing and frequency offset
// synchronizer: controller commands, datapath status and CORDIC tables.
// ----------------------------------------------------------------------------
package ocs_pkg;

    localparam int CORDIC_STEPS = 14;
    localparam int GAIN_COMP    = 19898;
    localparam int CW           = 48;
    localparam int ZW           = 18;
    localparam int PER_W        = 14;

    typedef enum logic [1:0] {
        CFG_FFT_LEN   = 2'd0,
        CFG_CP_LEN    = 2'd1,
        CFG_BLOCK_LEN = 2'd2,
        CFG_SYNC_EN   = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic load;
        logic clr;
        logic fetch;
        logic mul;
        logic acc;
        logic cord_run;
        logic gain;
        logic rnd;
        logic pwr_re;
        logic pwr_im;
        logic cmp;
        logic angle;
        logic div_q_ld;
        logic div_r_ld;
        logic div_run;
        logic step_set;
        logic lock;
        logic blk_done;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic bypass;
        logic cfg_wr;
        logic clr_last;
        logic cord_last;
        logic div_last;
        logic in_window;
        logic take;
        logic blk_end;
        logic blk_long;
        logic locked;
        logic out_free;
    } stat_t;

    function automatic logic [ZW-1:0] atan_lut(input logic [3:0] i);
        logic [ZW-1:0] a;
        case (i)
            4'd0:    a = ZW'(8192);
            4'd1:    a = ZW'(4836);
            4'd2:    a = ZW'(2555);
            4'd3:    a = ZW'(1297);
            4'd4:    a = ZW'(651);
            4'd5:    a = ZW'(326);
            4'd6:    a = ZW'(163);
            4'd7:    a = ZW'(81);
            4'd8:    a = ZW'(41);
            4'd9:    a = ZW'(20);
            4'd10:   a = ZW'(10);
            4'd11:   a = ZW'(5);
            4'd12:   a = ZW'(3);
            4'd13:   a = ZW'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

FILE: sv/ocs_ctrl.sv
// ----------------------------------------------------------------------------
// ocs_ctrl
// Sequencer: steps one sample through fetch, correlation, rotation, peak
// search and the per-block divisions, and runs the memory clearing pass.
// ----------------------------------------------------------------------------
module ocs_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  ocs_pkg::stat_t stat,
    output ocs_pkg::cmd_t  cmd
);

    typedef enum logic [18:0] {
        ST_IDLE   = 19'h00001,
        ST_CLEAR  = 19'h00002,
        ST_FETCH  = 19'h00004,
        ST_MUL    = 19'h00008,
        ST_ACC    = 19'h00010,
        ST_ROT    = 19'h00020,
        ST_GAIN   = 19'h00040,
        ST_RND    = 19'h00080,
        ST_PWR_RE = 19'h00100,
        ST_PWR_IM = 19'h00200,
        ST_CMP    = 19'h00400,
        ST_VEC    = 19'h00800,
        ST_ANGLE  = 19'h01000,
        ST_BLK    = 19'h02000,
        ST_DIVQ   = 19'h04000,
        ST_STEP   = 19'h08000,
        ST_DIVR   = 19'h10000,
        ST_LOCK   = 19'h20000,
        ST_OUT    = 19'h40000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = stat.bypass ? ST_OUT : ST_FETCH;
                end
            end
            ST_CLEAR: begin
                cmd.clr = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc    = 1'b1;
                state_next = ST_ROT;
            end
            ST_ROT: begin
                cmd.cord_run = 1'b1;
                if (stat.cord_last) begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN: begin
                cmd.gain   = 1'b1;
                state_next = ST_RND;
            end
            ST_RND: begin
                cmd.rnd    = 1'b1;
                state_next = stat.in_window ? ST_PWR_RE : ST_BLK;
            end
            ST_PWR_RE: begin
                cmd.pwr_re = 1'b1;
                state_next = ST_PWR_IM;
            end
            ST_PWR_IM: begin
                cmd.pwr_im = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                cmd.cmp    = 1'b1;
                state_next = stat.take ? ST_VEC : ST_BLK;
            end
            ST_VEC: begin
                cmd.cord_run = 1'b1;
                if (stat.cord_last) begin
                    state_next = ST_ANGLE;
                end
            end
            ST_ANGLE: begin
                cmd.angle  = 1'b1;
                state_next = ST_BLK;
            end
            ST_BLK: begin
                if (stat.blk_end && stat.blk_long) begin
                    cmd.div_q_ld = 1'b1;
                    state_next   = ST_DIVQ;
                end else begin
                    cmd.blk_done = 1'b1;
                    state_next   = ST_OUT;
                end
            end
            ST_DIVQ: begin
                cmd.div_run = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP: begin
                cmd.step_set = 1'b1;
                if (stat.locked) begin
                    cmd.blk_done = 1'b1;
                    state_next   = ST_OUT;
                end else begin
                    cmd.div_r_ld = 1'b1;
                    state_next   = ST_DIVR;
                end
            end
            ST_DIVR: begin
                cmd.div_run = 1'b1;
                if (stat.div_last) begin
                    state_next = ST_LOCK;
                end
            end
            ST_LOCK: begin
                cmd.lock     = 1'b1;
                cmd.blk_done = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
        if (stat.cfg_wr) begin
            state_next = ST_CLEAR;
        end
    end

endmodule

FILE: sv/ocs_dp.sv
// ----------------------------------------------------------------------------
// ocs_dp
// Datapath: configuration registers, sample delay line, lag product ring,
// correlation sums, shared CORDIC, shared restoring divider, output register.
// ----------------------------------------------------------------------------
module ocs_dp #(
    parameter int MAX_FFT     = 4096,
    parameter int MAX_CP      = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_valid,
    input  logic [1:0]     cfg_index,
    input  logic [15:0]    cfg_data,
    input  logic [31:0]    s_tdata,
    input  logic           m_tready,
    output logic           m_tvalid,
    output logic [31:0]    m_tdata,
    output logic           m_tuser,
    input  ocs_pkg::cmd_t  cmd,
    output ocs_pkg::stat_t stat
);

    localparam int DLY_AW = $clog2(MAX_FFT);
    localparam int DW     = DLY_AW + 1;
    localparam int RING_AW = $clog2(MAX_CP);
    localparam int RW     = RING_AW + 1;
    localparam int CLR_N  = (MAX_FFT > MAX_CP) ? MAX_FFT : MAX_CP;
    localparam int CLR_W  = $clog2(CLR_N);
    localparam int PW     = ocs_pkg::PER_W;
    localparam int CW     = ocs_pkg::CW;
    localparam int ZW     = ocs_pkg::ZW;
    localparam logic signed [42:0] SAT_HI = (43'sd1 <<< (SAMPLE_BITS - 1)) - 43'sd1;
    localparam logic signed [42:0] SAT_LO = -(43'sd1 <<< (SAMPLE_BITS - 1));

    logic [12:0] fft_len_reg;
    logic [9:0]  cp_len_reg;
    logic [15:0] block_len_reg;
    logic        sync_en_reg;
    logic        cfg_wr;

    assign cfg_wr = cfg_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fft_len_reg   <= 13'd64;
            cp_len_reg    <= 10'd16;
            block_len_reg <= 16'd8192;
            sync_en_reg   <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                ocs_pkg::CFG_FFT_LEN:   fft_len_reg   <= cfg_data[12:0];
                ocs_pkg::CFG_CP_LEN:    cp_len_reg    <= cfg_data[9:0];
                ocs_pkg::CFG_BLOCK_LEN: block_len_reg <= cfg_data;
                ocs_pkg::CFG_SYNC_EN:   sync_en_reg   <= cfg_data[0];
                default:                sync_en_reg   <= sync_en_reg;
            endcase
        end
    end

    logic [PW-1:0] per, first;
    logic [PW:0]   last_pos;
    assign per      = PW'(fft_len_reg) + PW'(cp_len_reg);
    assign first    = per - PW'(1);
    assign last_pos = {per, 1'b0} - (PW+1)'(2);

    // sample, pointers, scalar state
    logic signed [15:0] xr_reg, xi_reg;
    logic [DLY_AW-1:0]  dly_wr_reg;
    logic [RING_AW-1:0] ring_wr_reg;
    logic [CLR_W-1:0]   clr_cnt_reg;
    logic signed [43:0] sum_re_reg, sum_im_reg;
    logic [63:0]        best_power_reg;
    logic [15:0]        best_angle_reg;
    logic [PW-1:0]      best_lag_reg;
    logic [15:0]        block_pos_reg;
    logic [31:0]        phase_acc_reg, phase_step_reg;
    logic [PW-1:0]      cd_reg;
    logic               locked_reg;

    // delay line and ring addressing
    logic [DW-1:0]      rd_sum;
    logic [DLY_AW-1:0]  rd_addr;
    logic [RW-1:0]      old_sum;
    logic [RING_AW-1:0] old_addr;
    assign rd_sum   = {1'b0, dly_wr_reg} + DW'(MAX_FFT) - DW'(fft_len_reg);
    assign rd_addr  = (rd_sum >= DW'(MAX_FFT)) ? DLY_AW'(rd_sum - DW'(MAX_FFT))
                                               : DLY_AW'(rd_sum);
    assign old_sum  = {1'b0, ring_wr_reg} + RW'(MAX_CP) - RW'(cp_len_reg);
    assign old_addr = (old_sum >= RW'(MAX_CP)) ? RING_AW'(old_sum - RW'(MAX_CP))
                                               : RING_AW'(old_sum);

    logic [31:0] dly_mem [MAX_FFT];
    logic [31:0] dly_q_reg;
    logic        dly_we;
    logic [DLY_AW-1:0] dly_wa;
    logic [31:0] dly_wd;

    always_comb begin
        dly_we = cmd.fetch || (cmd.clr && (32'(clr_cnt_reg) < MAX_FFT));
        dly_wa = cmd.clr ? clr_cnt_reg[DLY_AW-1:0] : dly_wr_reg;
        dly_wd = cmd.clr ? 32'd0 : {xi_reg, xr_reg};
    end

    always_ff @(posedge aclk) begin
        if (cmd.fetch) begin
            dly_q_reg <= dly_mem[rd_addr];
        end
        if (dly_we) begin
            dly_mem[dly_wa] <= dly_wd;
        end
    end

    logic signed [32:0] ring_re_mem [MAX_CP];
    logic signed [32:0] ring_im_mem [MAX_CP];
    logic signed [32:0] ring_re_q_reg, ring_im_q_reg;
    logic signed [31:0] p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg;
    logic signed [32:0] pr, pi;
    logic               ring_we;
    logic [RING_AW-1:0] ring_wa;

    assign pr = 33'(p_rr_reg) + 33'(p_ii_reg);
    assign pi = 33'(p_ir_reg) - 33'(p_ri_reg);

    always_comb begin
        ring_we = cmd.acc || (cmd.clr && (32'(clr_cnt_reg) < MAX_CP));
        ring_wa = cmd.clr ? clr_cnt_reg[RING_AW-1:0] : ring_wr_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.fetch) begin
            ring_re_q_reg <= ring_re_mem[old_addr];
            ring_im_q_reg <= ring_im_mem[old_addr];
        end
        if (ring_we) begin
            ring_re_mem[ring_wa] <= cmd.clr ? 33'sd0 : pr;
            ring_im_mem[ring_wa] <= cmd.clr ? 33'sd0 : pi;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            p_rr_reg <= xr_reg * $signed(dly_q_reg[15:0]);
            p_ii_reg <= xi_reg * $signed(dly_q_reg[31:16]);
            p_ir_reg <= xi_reg * $signed(dly_q_reg[15:0]);
            p_ri_reg <= xr_reg * $signed(dly_q_reg[31:16]);
        end
    end

    // shared CORDIC
    logic signed [CW-1:0] cx_reg, cy_reg, xs, ys, vx, vy;
    logic signed [ZW-1:0] cz_reg, z0;
    logic [3:0]           citer_reg;
    logic                 cvec_reg, czero_reg, up;
    logic [ZW-1:0]        atan_v;

    assign xs     = cx_reg >>> citer_reg;
    assign ys     = cy_reg >>> citer_reg;
    assign atan_v = ocs_pkg::atan_lut(citer_reg);
    assign up     = cvec_reg ? !cy_reg[CW-1] : cz_reg[ZW-1];
    assign z0     = ZW'($signed(phase_acc_reg[31:16]));
    assign vx     = CW'(sum_re_reg);
    assign vy     = CW'(sum_im_reg);

    // power and peak decision
    logic [43:0]  abs_re, abs_im;
    logic [31:0]  mag_re, mag_im;
    logic [63:0]  sq_re_reg, sq_im_reg, pw;
    logic         take;
    assign abs_re = sum_re_reg[43] ? 44'(-sum_re_reg) : 44'(sum_re_reg);
    assign abs_im = sum_im_reg[43] ? 44'(-sum_im_reg) : 44'(sum_im_reg);
    assign mag_re = abs_re[41:10];
    assign mag_im = abs_im[41:10];
    assign pw     = sq_re_reg + sq_im_reg;
    assign take   = (block_pos_reg == 16'(first)) || (pw > best_power_reg);

    always_ff @(posedge aclk) begin
        if (cmd.pwr_re) begin
            sq_re_reg <= mag_re * mag_re;
        end
        if (cmd.pwr_im) begin
            sq_im_reg <= mag_im * mag_im;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.acc) begin
            citer_reg <= '0;
            cvec_reg  <= 1'b0;
            czero_reg <= 1'b0;
            if (z0 > ZW'(16384)) begin
                cx_reg <= -(CW'(xi_reg) <<< 8);
                cy_reg <= CW'(xr_reg) <<< 8;
                cz_reg <= z0 - ZW'(16384);
            end else if (z0 < -ZW'(16384)) begin
                cx_reg <= CW'(xi_reg) <<< 8;
                cy_reg <= -(CW'(xr_reg) <<< 8);
                cz_reg <= z0 + ZW'(16384);
            end else begin
                cx_reg <= CW'(xr_reg) <<< 8;
                cy_reg <= CW'(xi_reg) <<< 8;
                cz_reg <= z0;
            end
        end else if (cmd.cmp && take) begin
            citer_reg <= '0;
            cvec_reg  <= 1'b1;
            czero_reg <= (sum_re_reg == 44'sd0) && (sum_im_reg == 44'sd0);
            if (vx < 0 && vy >= 0) begin
                cx_reg <= vy;
                cy_reg <= -vx;
                cz_reg <= ZW'(16384);
            end else if (vx < 0) begin
                cx_reg <= -vy;
                cy_reg <= vx;
                cz_reg <= -ZW'(16384);
            end else begin
                cx_reg <= vx;
                cy_reg <= vy;
                cz_reg <= '0;
            end
        end else if (cmd.cord_run) begin
            citer_reg <= citer_reg + 4'd1;
            if (up) begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + $signed(atan_v);
            end else begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - $signed(atan_v);
            end
        end
    end

    // gain compensation and saturation
    logic signed [42:0] gx_reg, gy_reg, rx, ry, sx, sy;
    assign rx = (gx_reg + 43'sd4194304) >>> 23;
    assign ry = (gy_reg + 43'sd4194304) >>> 23;
    assign sx = (rx > SAT_HI) ? SAT_HI : ((rx < SAT_LO) ? SAT_LO : rx);
    assign sy = (ry > SAT_HI) ? SAT_HI : ((ry < SAT_LO) ? SAT_LO : ry);

    always_ff @(posedge aclk) begin
        if (cmd.gain) begin
            gx_reg <= 43'($signed(cx_reg[26:0]) * 16'sd19898);
            gy_reg <= 43'($signed(cy_reg[26:0]) * 16'sd19898);
        end
    end

    // shared restoring divider
    logic [32:0]   dq_reg;
    logic [PW-1:0] drem_reg, dsr_reg;
    logic [5:0]    dcnt_reg;
    logic [PW:0]   rs;
    logic [16:0]   ang_mag;
    assign rs      = {drem_reg, dq_reg[32]};
    assign ang_mag = best_angle_reg[15] ? 17'(-$signed(best_angle_reg))
                                        : 17'(best_angle_reg);

    always_ff @(posedge aclk) begin
        if (cmd.div_q_ld) begin
            dq_reg   <= {ang_mag, 16'd0} + 33'(fft_len_reg[12:1]);
            dsr_reg  <= PW'(fft_len_reg);
            drem_reg <= '0;
            dcnt_reg <= '0;
        end else if (cmd.div_r_ld) begin
            dq_reg   <= 33'(block_len_reg);
            dsr_reg  <= per;
            drem_reg <= '0;
            dcnt_reg <= '0;
        end else if (cmd.div_run) begin
            dcnt_reg <= dcnt_reg + 6'd1;
            if (rs >= {1'b0, dsr_reg}) begin
                drem_reg <= PW'(rs - {1'b0, dsr_reg});
                dq_reg   <= {dq_reg[31:0], 1'b1};
            end else begin
                drem_reg <= PW'(rs);
                dq_reg   <= {dq_reg[31:0], 1'b0};
            end
        end
    end

    logic [PW:0] cd_raw;
    assign cd_raw = (PW+1)'(best_lag_reg) + (PW+1)'(per) - (PW+1)'(drem_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            xr_reg <= s_tdata[15:0];
            xi_reg <= s_tdata[31:16];
        end
    end

    // scalar state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dly_wr_reg     <= '0;
            ring_wr_reg    <= '0;
            clr_cnt_reg    <= '0;
            sum_re_reg     <= '0;
            sum_im_reg     <= '0;
            best_power_reg <= '0;
            best_angle_reg <= '0;
            best_lag_reg   <= '0;
            block_pos_reg  <= '0;
            phase_acc_reg  <= '0;
            phase_step_reg <= '0;
            cd_reg         <= '0;
            locked_reg     <= 1'b0;
        end else if (cfg_wr) begin
            dly_wr_reg     <= '0;
            ring_wr_reg    <= '0;
            clr_cnt_reg    <= '0;
            sum_re_reg     <= '0;
            sum_im_reg     <= '0;
            best_power_reg <= '0;
            best_angle_reg <= '0;
            best_lag_reg   <= '0;
            block_pos_reg  <= '0;
            cd_reg         <= '0;
            locked_reg     <= 1'b0;
        end else begin
            if (cmd.clr) begin
                clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
            end
            if (cmd.fetch) begin
                dly_wr_reg <= (dly_wr_reg == DLY_AW'(MAX_FFT - 1)) ? '0
                                                                  : dly_wr_reg + DLY_AW'(1);
            end
            if (cmd.acc) begin
                sum_re_reg    <= sum_re_reg + 44'(pr) - 44'(ring_re_q_reg);
                sum_im_reg    <= sum_im_reg + 44'(pi) - 44'(ring_im_q_reg);
                ring_wr_reg   <= (ring_wr_reg == RING_AW'(MAX_CP - 1)) ? '0
                                                                      : ring_wr_reg + RING_AW'(1);
                phase_acc_reg <= phase_acc_reg + phase_step_reg;
                if (locked_reg) begin
                    cd_reg <= (cd_reg == '0) ? first : cd_reg - PW'(1);
                end
            end
            if (cmd.cmp && take) begin
                best_power_reg <= pw;
                best_lag_reg   <= PW'(block_pos_reg) - first;
            end
            if (cmd.angle) begin
                best_angle_reg <= czero_reg ? 16'd0 : cz_reg[15:0];
            end
            if (cmd.step_set) begin
                phase_step_reg <= ($signed(best_angle_reg) > 16'sd0) ? 32'd0 - dq_reg[31:0]
                                                                    : dq_reg[31:0];
            end
            if (cmd.lock) begin
                cd_reg     <= (cd_raw >= (PW+1)'(per)) ? PW'(cd_raw - (PW+1)'(per))
                                                       : PW'(cd_raw);
                locked_reg <= 1'b1;
            end
            if (cmd.blk_done) begin
                if (stat.blk_end) begin
                    best_power_reg <= '0;
                    best_angle_reg <= '0;
                    best_lag_reg   <= '0;
                    block_pos_reg  <= '0;
                end else begin
                    block_pos_reg <= block_pos_reg + 16'd1;
                end
            end
        end
    end

    // working result and output register
    logic        m_valid_reg;
    logic [15:0] wk_re_reg, wk_im_reg;
    logic        wk_sym_reg;
    logic [15:0] res_re_reg, res_im_reg;
    logic        res_sym_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            wk_re_reg  <= s_tdata[15:0];
            wk_im_reg  <= s_tdata[31:16];
            wk_sym_reg <= 1'b0;
        end
        if (cmd.acc) begin
            wk_sym_reg <= locked_reg && (cd_reg == '0);
        end
        if (cmd.rnd) begin
            wk_re_reg <= sx[15:0];
            wk_im_reg <= sy[15:0];
        end
        if (cmd.out_load) begin
            res_re_reg  <= wk_re_reg;
            res_im_reg  <= wk_im_reg;
            res_sym_reg <= wk_sym_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {res_im_reg, res_re_reg};
    assign m_tuser  = res_sym_reg;

    always_comb begin
        stat.bypass    = !sync_en_reg || (fft_len_reg == 13'd0) ||
                         (32'(fft_len_reg) > MAX_FFT) || (cp_len_reg == 10'd0) ||
                         (32'(cp_len_reg) > MAX_CP) || (block_len_reg < 16'd16);
        stat.cfg_wr    = cfg_wr;
        stat.clr_last  = (clr_cnt_reg == CLR_W'(CLR_N - 1));
        stat.cord_last = (citer_reg == 4'(ocs_pkg::CORDIC_STEPS - 1));
        stat.div_last  = (dcnt_reg == 6'd32);
        stat.in_window = (17'(block_pos_reg) >= 17'(first)) &&
                         (17'(block_pos_reg) <= 17'(last_pos));
        stat.take      = take;
        stat.blk_end   = (17'(block_pos_reg) + 17'd1) >= 17'(block_len_reg);
        stat.blk_long  = 17'(block_len_reg) >= 17'(per);
        stat.locked    = locked_reg;
        stat.out_free  = !m_valid_reg || m_tready;
    end

`ifndef SYNTHESIS
    a_lock_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.lock && !cfg_wr) |=> (locked_reg && (cd_reg < per)))
        else $error("symbol countdown out of range after lock");

    a_first_lag: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.cmp && !cfg_wr && (block_pos_reg == 16'(first))) |=> (best_lag_reg == '0))
        else $error("first search position must take lag zero");

    a_sym_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.acc && locked_reg && (cd_reg == '0)) |=> wk_sym_reg)
        else $error("symbol start missed at countdown expiry");
`endif

endmodule

FILE: sv/ofdm_cp_timing_cfo_sync.sv
// ----------------------------------------------------------------------------
// ofdm_cp_timing_cfo_sync
// Cyclic prefix correlation timing and carrier frequency offset correction.
// ----------------------------------------------------------------------------
// A bypassed item goes to the output register; others are rotated and, in
// the search window, a new peak is vectored (14-step shared CORDIC for both
// angles). At block end the 33-step divider finds the phase step, then, until
// locked, the timing. One item in process; the next is accepted in the cycle
// m_tvalid rises. Reset (synchronous, active low) and every configuration
// write start a clearing pass of max(MAX_FFT, MAX_CP) words with s_tready low.
module ofdm_cp_timing_cfo_sync #(
    parameter int MAX_FFT     = 4096,
    parameter int MAX_CP      = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // in_re[15:0], in_im[31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_re[15:0], out_im[31:16]
    output logic        m_tuser    // symbol_start
);

    ocs_pkg::cmd_t  cmd;
    ocs_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    ocs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ocs_dp #(
        .MAX_FFT     (MAX_FFT),
        .MAX_CP      (MAX_CP),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
